/* rtl/rcfd_pkg.sv */
// rcfd_pkg: shared types and constants of the RC serial frame decoder.
// Used by the interfaces, controller, datapath and top level. No dependencies.
package rcfd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned VAL_W       = 16;
    localparam int unsigned STORE_DEPTH = 14;

    localparam logic [BYTE_W-1:0] START_BYTE_0 = 8'h20;
    localparam logic [BYTE_W-1:0] START_BYTE_1 = 8'h40;
    localparam logic [POS_W-1:0]  POS_START0   = 5'd0;
    localparam logic [POS_W-1:0]  POS_START1   = 5'd1;
    localparam logic [POS_W-1:0]  POS_CK_LOW   = 5'd30;
    localparam logic [POS_W-1:0]  POS_CK_HIGH  = 5'd31;

    typedef enum logic {
        ST_RECV,
        ST_DRAIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input transaction this cycle
        logic load;     // move next stored channel into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic frame_ok;   // final byte accepted and checksum matched
        logic drain_last; // the channel being loaded is the last one
        logic out_free;   // output register can take a new result
    } t_sts;

endpackage

/* rtl/rcfd_if.sv */
// Channel interfaces of the RC serial frame decoder: serial byte input and
// channel result output, each with valid/ready. Depends on rcfd_pkg.
interface rcfd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [rcfd_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcfd_chan_if;
    logic                          valid;
    logic                          ready;
    logic [rcfd_pkg::IDX_W-1:0]    channel_index;
    logic [rcfd_pkg::VAL_W-1:0]    channel_value;
    logic                          last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input last_channel, output ready);
endinterface

/* rtl/rcfd_datapath.sv */
// rcfd_datapath: frame position, running sum, channel store, drain counter
// and output register. Depends on rcfd_pkg.
module rcfd_datapath #(
    parameter int unsigned CHANNELS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rcfd_pkg::t_cmd                i_cmd,
    output rcfd_pkg::t_sts                o_sts,
    input  logic [rcfd_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [rcfd_pkg::IDX_W-1:0]    o_channel_index,
    output logic [rcfd_pkg::VAL_W-1:0]    o_channel_value,
    output logic                          o_last_channel
);

    localparam logic [rcfd_pkg::IDX_W-1:0] LAST_IDX = rcfd_pkg::IDX_W'(CHANNELS - 1);

    logic [rcfd_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [rcfd_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [rcfd_pkg::BYTE_W-1:0] r_low, n_low;
    logic [rcfd_pkg::IDX_W-1:0]  r_drain;
    logic                        r_out_valid;
    logic [rcfd_pkg::IDX_W-1:0]  r_out_idx;
    logic [rcfd_pkg::VAL_W-1:0]  r_out_val;
    logic                        r_out_last;

    logic [rcfd_pkg::VAL_W-1:0]  r_store [rcfd_pkg::STORE_DEPTH];

    logic [rcfd_pkg::SUM_W-1:0]  sum_add;
    logic [rcfd_pkg::IDX_W-1:0]  slot;
    logic                        store_we;
    logic                        ck_match;

    assign sum_add  = r_sum + rcfd_pkg::SUM_W'(i_rx_byte);
    // odd positions 3..29 close channel words 0..13
    assign slot     = r_pos[rcfd_pkg::POS_W-1:1] - rcfd_pkg::IDX_W'(1);
    assign ck_match = ({i_rx_byte, r_low} == ~r_sum);

    always_comb begin
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_low    = r_low;
        store_we = 1'b0;
        if (i_cmd.accept) begin
            if (r_pos == rcfd_pkg::POS_START0) begin
                if (i_rx_byte == rcfd_pkg::START_BYTE_0) begin
                    n_sum = rcfd_pkg::SUM_W'(i_rx_byte);
                    n_pos = rcfd_pkg::POS_START1;
                end
            end else if (r_pos == rcfd_pkg::POS_START1) begin
                if (i_rx_byte == rcfd_pkg::START_BYTE_1) begin
                    n_sum = sum_add;
                    n_pos = r_pos + rcfd_pkg::POS_W'(1);
                end else begin
                    n_pos = rcfd_pkg::POS_START0;
                end
            end else if (r_pos < rcfd_pkg::POS_CK_LOW) begin
                n_sum = sum_add;
                n_pos = r_pos + rcfd_pkg::POS_W'(1);
                if (!r_pos[0]) begin
                    n_low = i_rx_byte;
                end else begin
                    store_we = 1'b1;
                end
            end else if (r_pos == rcfd_pkg::POS_CK_LOW) begin
                n_low = i_rx_byte;
                n_pos = rcfd_pkg::POS_CK_HIGH;
            end else begin
                n_pos = rcfd_pkg::POS_START0;
            end
        end
    end

    always_comb begin
        o_sts.frame_ok   = i_cmd.accept && (r_pos == rcfd_pkg::POS_CK_HIGH) && ck_match;
        o_sts.drain_last = (r_drain == LAST_IDX);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_low       <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            r_low <= n_low;
            if (i_cmd.load) begin
                r_drain     <= (r_drain == LAST_IDX) ? '0 : r_drain + rcfd_pkg::IDX_W'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[slot] <= {i_rx_byte, r_low};
        end
        if (i_cmd.load) begin
            r_out_idx  <= r_drain;
            r_out_val  <= r_store[r_drain];
            r_out_last <= (r_drain == LAST_IDX);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_idx;
    assign o_channel_value = r_out_val;
    assign o_last_channel  = r_out_last;

endmodule

/* rtl/rcfd_ctrl.sv */
// rcfd_ctrl: receive/drain state machine of the RC serial frame decoder.
// Depends on rcfd_pkg.
module rcfd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rcfd_pkg::t_sts i_sts,
    output rcfd_pkg::t_cmd o_cmd
);

    rcfd_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rcfd_pkg::ST_RECV: begin
                if (i_sts.frame_ok) begin
                    n_state = rcfd_pkg::ST_DRAIN;
                end
            end
            rcfd_pkg::ST_DRAIN: begin
                if (i_sts.out_free && i_sts.drain_last) begin
                    n_state = rcfd_pkg::ST_RECV;
                end
            end
            default: n_state = rcfd_pkg::ST_RECV;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            rcfd_pkg::ST_RECV: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            rcfd_pkg::ST_DRAIN: begin
                o_cmd.load = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcfd_pkg::ST_RECV;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/rc_serial_frame_decoder.sv */
// rc_serial_frame_decoder: top level, joins controller and datapath.
// Depends on rcfd_pkg, rcfd_if, rcfd_ctrl, rcfd_datapath.
//
//   port   dir  payload                                      per transaction
//   i_rx   in   rx_byte[7:0]                                 one serial byte
//   o_ch   out  channel_index[3:0], channel_value[15:0],     one channel word
//               last_channel
//
// While receiving, the block takes a new byte every clock. After the final byte
// of a frame with a good checksum, the block drains CHANNELS results, one per
// cycle while o_ch is not stalled, from the channel store into the output
// register; i_rx.ready is low meanwhile. o_ch stalls hold the drain; the next
// byte is taken while the last result still waits. Reset is synchronous and
// active low.
module rc_serial_frame_decoder #(
    parameter int unsigned CHANNELS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcfd_byte_if.sink   i_rx,
    rcfd_chan_if.source o_ch
);

    rcfd_pkg::t_cmd cmd;
    rcfd_pkg::t_sts sts;

    rcfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .o_in_ready (i_rx.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rcfd_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_rx_byte       (i_rx.rx_byte),
        .i_out_ready     (o_ch.ready),
        .o_out_valid     (o_ch.valid),
        .o_channel_index (o_ch.channel_index),
        .o_channel_value (o_ch.channel_value),
        .o_last_channel  (o_ch.last_channel)
    );

endmodule

/* rtl/rcfd_checker.sv */
// rcfd_checker: port-level assertions for rc_serial_frame_decoder, bound to
// the top level. Depends on rcfd_pkg.
module rcfd_checker #(
    parameter int unsigned CHANNELS = 14
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [rcfd_pkg::IDX_W-1:0]  i_channel_index,
    input logic [rcfd_pkg::VAL_W-1:0]  i_channel_value,
    input logic                        i_last_channel
);

    localparam logic [rcfd_pkg::IDX_W-1:0] LAST_IDX = rcfd_pkg::IDX_W'(CHANNELS - 1);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_channel_index)
            && $stable(i_channel_value) && $stable(i_last_channel))
        else $error("stalled result changed");

    // last marker only on the top channel
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_channel |-> i_channel_index == LAST_IDX)
        else $error("last_channel on wrong index");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_channel_index <= LAST_IDX)
        else $error("channel index out of range");

    // no bytes taken while a frame is still draining
    a_drain_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_channel |-> !i_in_ready)
        else $error("input taken during drain");

    // results of a frame come in order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_channel |=>
            i_out_valid && i_channel_index == $past(i_channel_index) + 4'd1)
        else $error("channel order broken");

endmodule

bind rc_serial_frame_decoder rcfd_checker #(
    .CHANNELS (CHANNELS)
) u_rcfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_rx.ready),
    .i_out_valid     (o_ch.valid),
    .i_out_ready     (o_ch.ready),
    .i_channel_index (o_ch.channel_index),
    .i_channel_value (o_ch.channel_value),
    .i_last_channel  (o_ch.last_channel)
);

/* test/tb_rc_serial_frame_decoder.sv */
// Testbench for rc_serial_frame_decoder: serial bytes in, channel words out.
// Depends on rcfd_pkg, rcfd_if and the decoder RTL; predicts every result itself.
module tb_rc_serial_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CHANNELS    = 14;
    localparam int unsigned FRAME_LEN   = 32;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_WAIT  = 40;

    typedef struct {
        logic [rcfd_pkg::IDX_W-1:0] index;
        logic [rcfd_pkg::VAL_W-1:0] value;
        logic                       last;
    } t_chan_word;

    logic i_clk;
    logic i_rst_n;

    rcfd_byte_if rx_if ();
    rcfd_chan_if ch_if ();

    rc_serial_frame_decoder #(.CHANNELS(CHANNELS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_ch    (ch_if)
    );

    // frame tracker state
    logic [rcfd_pkg::POS_W-1:0]  frame_pos;
    logic [rcfd_pkg::SUM_W-1:0]  frame_sum;
    logic [rcfd_pkg::BYTE_W-1:0] low_hold;
    logic [rcfd_pkg::VAL_W-1:0]  chan_words [rcfd_pkg::STORE_DEPTH];

    t_chan_word  expected_chan_q [$];
    int unsigned error_count;
    int unsigned bytes_sent;
    bit          gaps_on;
    bit          stalls_on;
    int unsigned stall_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Track one accepted byte and queue the channel words a good frame releases.
    function automatic void track_rx_byte(input logic [rcfd_pkg::BYTE_W-1:0] b);
        logic [rcfd_pkg::VAL_W-1:0] ck;
        t_chan_word                 w;
        if (frame_pos == rcfd_pkg::POS_START0) begin
            if (b == rcfd_pkg::START_BYTE_0) begin
                frame_sum = rcfd_pkg::SUM_W'(b);
                frame_pos = rcfd_pkg::POS_START1;
            end
        end else if (frame_pos == rcfd_pkg::POS_START1) begin
            if (b != rcfd_pkg::START_BYTE_1) begin
                frame_pos = rcfd_pkg::POS_START0;   // this byte is not a new start
            end else begin
                frame_sum = frame_sum + rcfd_pkg::SUM_W'(b);
                frame_pos = rcfd_pkg::POS_START1 + 5'd1;
            end
        end else if (frame_pos < rcfd_pkg::POS_CK_LOW) begin
            frame_sum = frame_sum + rcfd_pkg::SUM_W'(b);
            if (!frame_pos[0]) begin
                low_hold = b;
            end else begin
                chan_words[rcfd_pkg::IDX_W'((frame_pos - 5'd3) >> 1)] = {b, low_hold};
            end
            frame_pos = frame_pos + 5'd1;
        end else if (frame_pos == rcfd_pkg::POS_CK_LOW) begin
            low_hold  = b;
            frame_pos = rcfd_pkg::POS_CK_HIGH;
        end else begin
            frame_pos = rcfd_pkg::POS_START0;
            ck = {b, low_hold};
            if (ck == rcfd_pkg::VAL_W'(16'hFFFF - frame_sum)) begin
                for (int k = 0; k < CHANNELS; k++) begin
                    w.index = rcfd_pkg::IDX_W'(k);
                    w.value = chan_words[k];
                    w.last  = (k == CHANNELS - 1);
                    expected_chan_q.push_back(w);
                end
            end
        end
    endfunction

    // Called at a rising edge; returns at the edge where the byte is taken.
    task automatic send_byte(input logic [rcfd_pkg::BYTE_W-1:0] b);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        track_rx_byte(b);
        bytes_sent++;
    endtask

    // fill < 0 gives random channel words, biased toward the extremes.
    // Sends only the first len bytes, so a cut-off frame is possible.
    task automatic send_frame(input bit good, input int fill, input int len);
        logic [rcfd_pkg::BYTE_W-1:0] fb [FRAME_LEN];
        logic [rcfd_pkg::VAL_W-1:0]  word;
        logic [rcfd_pkg::SUM_W-1:0]  sum;
        logic [rcfd_pkg::VAL_W-1:0]  ck;
        int unsigned                 pick;
        // bring the decoder back to hunting first
        while (frame_pos != rcfd_pkg::POS_START0) send_byte(8'h00);
        fb[0] = rcfd_pkg::START_BYTE_0;
        fb[1] = rcfd_pkg::START_BYTE_1;
        for (int k = 0; k < rcfd_pkg::STORE_DEPTH; k++) begin
            pick = $urandom_range(0, 7);
            if (fill >= 0)      word = rcfd_pkg::VAL_W'(fill);
            else if (pick == 0) word = 16'h0000;
            else if (pick == 1) word = 16'hFFFF;
            else                word = rcfd_pkg::VAL_W'($urandom);
            fb[2 + 2 * k] = word[7:0];
            fb[3 + 2 * k] = word[15:8];
        end
        sum = '0;
        for (int k = 0; k < rcfd_pkg::POS_CK_LOW; k++) sum = sum + rcfd_pkg::SUM_W'(fb[k]);
        ck = 16'hFFFF - sum;
        if (!good) ck = ck ^ rcfd_pkg::VAL_W'($urandom_range(1, 16'hFFFF));
        fb[rcfd_pkg::POS_CK_LOW]  = ck[7:0];
        fb[rcfd_pkg::POS_CK_HIGH] = ck[15:8];
        for (int k = 0; k < len; k++) send_byte(fb[k]);
    endtask

    task automatic test_start_hunt();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(rcfd_pkg::START_BYTE_1);
        send_byte(8'h21);
        // wrong second byte that is itself a start byte: not taken as a start
        send_byte(rcfd_pkg::START_BYTE_0);
        send_byte(rcfd_pkg::START_BYTE_0);
        send_byte(rcfd_pkg::START_BYTE_1);
        send_byte(rcfd_pkg::START_BYTE_0);
        send_byte(8'hBF);
    endtask

    task automatic test_extreme_frames();
        send_frame(1'b1, 16'h0000, FRAME_LEN);
        send_frame(1'b1, 16'hFFFF, FRAME_LEN);
        send_frame(1'b0, -1, FRAME_LEN);
    endtask

    task automatic test_random_traffic();
        int unsigned stop_at;
        int unsigned pick;
        stop_at = bytes_sent + 36;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0:       send_byte(rcfd_pkg::START_BYTE_0);
                        1:       send_byte(rcfd_pkg::START_BYTE_1);
                        default: send_byte(rcfd_pkg::BYTE_W'($urandom));
                    endcase
                end
            end else if (pick == 1) begin
                send_frame(1'b1, -1, $urandom_range(1, FRAME_LEN - 1));
            end else if (pick == 2) begin
                send_frame(1'b0, -1, FRAME_LEN);
            end else begin
                send_frame(1'b1, -1, FRAME_LEN);
            end
        end
    endtask

    task automatic test_back_to_back();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (2) send_frame(1'b1, -1, FRAME_LEN);
    endtask

    // result checker and sink-side stalls
    always @(posedge i_clk) begin
        t_chan_word w;
        if (i_rst_n && ch_if.valid && ch_if.ready) begin
            if (expected_chan_q.size() == 0) begin
                $error("unexpected channel result: index %0d value %h",
                       ch_if.channel_index, ch_if.channel_value);
                error_count++;
            end else begin
                w = expected_chan_q.pop_front();
                if (ch_if.channel_index !== w.index) begin
                    $error("channel_index: expected %0d, actual %0d",
                           w.index, ch_if.channel_index);
                    error_count++;
                end
                if (ch_if.channel_value !== w.value) begin
                    $error("channel_value: expected %h, actual %h",
                           w.value, ch_if.channel_value);
                    error_count++;
                end
                if (ch_if.last_channel !== w.last) begin
                    $error("last_channel: expected %0d, actual %0d",
                           w.last, ch_if.last_channel);
                    error_count++;
                end
            end
        end
        if (stalls_on && stall_left > 0) begin
            stall_left--;
            ch_if.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            ch_if.ready <= 1'b0;
        end else begin
            ch_if.ready <= 1'b1;
        end
    end

    // watchdog: too long without any transaction ends the run
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n && ((rx_if.valid && rx_if.ready) || (ch_if.valid && ch_if.ready)))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        ch_if.ready   = 1'b1;
        i_rst_n       = 1'b0;
        error_count   = 0;
        bytes_sent    = 0;
        stall_left    = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        frame_pos     = rcfd_pkg::POS_START0;
        frame_sum     = '0;
        low_hold      = '0;
        for (int k = 0; k < rcfd_pkg::STORE_DEPTH; k++) chan_words[k] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_start_hunt();
        test_extreme_frames();
        test_random_traffic();
        test_back_to_back();

        rx_if.valid <= 1'b0;
        while (expected_chan_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_chan_q.size() != 0) begin
            $error("%0d channel results never arrived", expected_chan_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/rcfd_pkg.sv
rtl/rcfd_if.sv
rtl/rcfd_datapath.sv
rtl/rcfd_ctrl.sv
rtl/rc_serial_frame_decoder.sv
rtl/rcfd_checker.sv
test/tb_rc_serial_frame_decoder.sv
